// ===== rtl/obbt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the order book best bid/ask tracker.
// Used by the arithmetic unit and the top level; no dependencies.
package obbt_pkg;

	localparam int KEY_W   = 64;
	localparam int PRICE_W = 64;
	localparam int QTY_W   = 32;

	typedef struct packed {
		logic               used;
		logic [KEY_W-1:0]   key;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} slot_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} lvl_t;

	typedef struct packed {
		logic             eq;
		logic             lt;
		logic             gt;
		logic             qle;
		logic [QTY_W-1:0] qsum;
		logic [QTY_W-1:0] qdiff;
	} alu_res_t;

endpackage

// ===== rtl/obbt_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module obbt_ram #(
	parameter int W  = 8,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/obbt_alu.sv =====
`timescale 1ns / 1ps
// Shared compare and quantity unit for key, price and level quantity checks.
// Depends on obbt_pkg.
module obbt_alu (
	input  logic [63:0]        a,
	input  logic [63:0]        b,
	input  logic [31:0]        qa,
	input  logic [31:0]        qb,
	output obbt_pkg::alu_res_t res
);
	import obbt_pkg::*;

	always_comb begin
		res.eq    = (a == b);
		res.lt    = ($signed(a) < $signed(b));
		res.gt    = ($signed(a) > $signed(b));
		res.qle   = (qa <= qb);
		res.qsum  = qa + qb;
		res.qdiff = qa - qb;
	end

endmodule

// ===== rtl/order_book_best_bid_ask_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the order book best bid/ask tracker: sequencer, hash table, level lists.
// Depends on obbt_pkg, obbt_ram and obbt_alu.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser {side_is_bid, opcode}, tdata {quantity, price, id}
// m_*      out  m_tvalid/m_tready  tuser {accepted}, tdata {ask qty, ask price, bid qty, bid price}
//
// One request at a time; s_tready is low while a request is in work.
// Time per request grows with hashing (longer if TABLE_SLOTS is not a power of two),
// table probes, levels scanned or shifted, and erase re-insertion walks.
// After reset a clearing pass over all TABLE_SLOTS slots runs before the first request.
// A result waits in the output register; the next request is taken meanwhile.
module order_book_best_bid_ask_tracker #(
	parameter int TABLE_SLOTS = 4096,
	parameter int LEVELS      = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // id, price, quantity
	input  logic [1:0]   s_tuser,  // opcode, side_is_bid
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,  // bid price, bid qty, ask price, ask qty
	output logic [0:0]   m_tuser   // accepted
);
	import obbt_pkg::*;

	localparam int TW = $clog2(TABLE_SLOTS);
	localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW = $clog2(LEVELS + 1);
	localparam int HX = TW + 16;
	localparam logic [TW-1:0] LAST_SLOT = TW'(TABLE_SLOTS - 1);
	localparam logic [TW:0]   NUM_SLOTS = (TW + 1)'(TABLE_SLOTS);
	localparam logic [CW-1:0] LVL_MAX   = CW'(LEVELS);
	localparam logic [16:0]   HMUL      = 17'((longint'(1) << HX) / TABLE_SLOTS);
	localparam logic [HX-1:0] NMODX     = HX'(TABLE_SLOTS);

	typedef enum logic [18:0] {
		S_CLR    = 19'h00001,
		S_IDLE   = 19'h00002,
		S_HOME   = 19'h00004,
		S_ST_RD  = 19'h00008,
		S_ST_CHK = 19'h00010,
		S_FD_RD  = 19'h00020,
		S_FD_CHK = 19'h00040,
		S_ER_CLR = 19'h00080,
		S_ER_RD  = 19'h00100,
		S_ER_CHK = 19'h00200,
		S_LA_RD  = 19'h00400,
		S_LA_CHK = 19'h00800,
		S_LI_RD  = 19'h01000,
		S_LI_WR  = 19'h02000,
		S_LR_RD  = 19'h04000,
		S_LR_CHK = 19'h08000,
		S_LD_RD  = 19'h10000,
		S_LD_WR  = 19'h20000,
		S_DONE   = 19'h40000
	} state_t;

	state_t        state_q;
	logic          op_q;
	slot_t         cur_q;
	logic [TW-1:0] pos_q, pcnt_q, epos_q, hrem_q;
	logic [TW:0]   ecnt_q;
	logic [1:0]    hcnt_q;
	logic          hph_q;
	logic [HX+16:0] hprod_q;
	logic          er_q, ok_q, ls_q;
	lvl_t          lp_q, best_bid_q, best_ask_q;
	logic [CW-1:0] li_q, at_q, bid_cnt_q, ask_cnt_q;
	logic          m_valid_q, m_ok_q;
	logic [191:0]  m_data_q;

	slot_t         tbl_rd, tbl_wd;
	logic          tbl_we;
	logic [TW-1:0] tbl_wa, tbl_ra;
	lvl_t          lv_rd, lv_wd;
	logic          lv_we;
	logic [CW-1:0] lv_widx, lv_ridx;
	alu_res_t      alu;
	logic [63:0]   alu_a, alu_b;

	logic [CW-1:0] n_cur;
	logic          tbl_phase, hit, better;
	logic [HX-1:0] hx, hqn, hr;
	logic [16:0]   hq;
	logic [TW-1:0] hred, pos_inc, epos_inc;

	obbt_ram #(.W($bits(slot_t)), .AW(TW)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_wa), .wdata(tbl_wd),
		.raddr(tbl_ra), .rdata(tbl_rd)
	);

	obbt_ram #(.W($bits(lvl_t)), .AW(LW + 1)) u_lvl (
		.clk(clk), .we(lv_we), .waddr({ls_q, lv_widx[LW-1:0]}), .wdata(lv_wd),
		.raddr({ls_q, lv_ridx[LW-1:0]}), .rdata(lv_rd)
	);

	obbt_alu u_alu (.a(alu_a), .b(alu_b), .qa(lv_rd.qty), .qb(lp_q.qty), .res(alu));

	assign tbl_phase = (state_q == S_ST_CHK) || (state_q == S_FD_CHK);
	assign alu_a     = tbl_phase ? cur_q.key : lp_q.price;
	assign alu_b     = tbl_phase ? tbl_rd.key : lv_rd.price;
	assign n_cur     = ls_q ? bid_cnt_q : ask_cnt_q;
	assign hit       = !tbl_rd.used || alu.eq;
	assign better    = ls_q ? alu.gt : alu.lt;
	assign hx        = {hrem_q, cur_q.key[{~hcnt_q, 4'b0000} +: 16]};
	assign hq        = hprod_q[HX+16:HX];
	assign hqn       = HX'(hq) * NMODX;
	assign hr        = hx - hqn;
	assign hred      = (hr >= NMODX) ? TW'(hr - NMODX) : hr[TW-1:0];
	assign pos_inc   = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
	assign epos_inc  = (epos_q == LAST_SLOT) ? '0 : epos_q + 1'b1;

	always_comb begin
		tbl_we  = 1'b0;
		tbl_wa  = pos_q;
		tbl_wd  = '0;
		tbl_ra  = pos_q;
		lv_we   = 1'b0;
		lv_widx = li_q;
		lv_wd   = lv_rd;
		lv_ridx = li_q;
		unique case (state_q)
			S_CLR: begin
				tbl_we = 1'b1;
			end
			S_ST_CHK: begin
				if (hit) begin
					tbl_we = 1'b1;
					tbl_wd = cur_q;
				end
			end
			S_ER_CLR: begin
				tbl_we = 1'b1;
				tbl_wa = epos_q;
			end
			S_ER_RD: begin
				tbl_ra = epos_q;
			end
			S_ER_CHK: begin
				tbl_we = tbl_rd.used;
				tbl_wa = epos_q;
			end
			S_LA_CHK: begin
				if (alu.eq) begin
					lv_we = 1'b1;
					lv_wd = '{price: lv_rd.price, qty: alu.qsum};
				end
			end
			S_LI_RD: begin
				lv_ridx = li_q - 1'b1;
				if (li_q == at_q) begin
					lv_we = 1'b1;
					lv_wd = lp_q;
				end
			end
			S_LI_WR: begin
				lv_we = 1'b1;
			end
			S_LR_CHK: begin
				if (alu.eq && !alu.qle) begin
					lv_we = 1'b1;
					lv_wd = '{price: lv_rd.price, qty: alu.qdiff};
				end
			end
			S_LD_RD: begin
				lv_ridx = li_q + 1'b1;
			end
			S_LD_WR: begin
				lv_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			pos_q      <= '0;
			bid_cnt_q  <= '0;
			ask_cnt_q  <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			if (lv_we && lv_widx == '0) begin
				if (ls_q) begin
					best_bid_q <= lv_wd;
				end else begin
					best_ask_q <= lv_wd;
				end
			end
			unique case (state_q)
				S_CLR: begin
					pos_q <= pos_inc;
					if (pos_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser[0];
						cur_q   <= '{used: 1'b1, key: s_tdata[63:0], side: s_tuser[1],
							price: s_tdata[127:64], qty: s_tdata[159:128]};
						er_q    <= 1'b0;
						hcnt_q  <= '0;
						hph_q   <= 1'b0;
						hrem_q  <= '0;
						state_q <= S_HOME;
					end
				end
				S_HOME: begin
					pcnt_q <= '0;
					if (POW2) begin
						pos_q   <= cur_q.key[TW-1:0];
						state_q <= (op_q && !er_q) ? S_FD_RD : S_ST_RD;
					end else if (!hph_q) begin
						hprod_q <= (HX + 17)'(hx) * (HX + 17)'(HMUL);
						hph_q   <= 1'b1;
					end else if (hcnt_q != 2'd3) begin
						hrem_q <= hred;
						hcnt_q <= hcnt_q + 1'b1;
						hph_q  <= 1'b0;
					end else begin
						pos_q   <= hred;
						state_q <= (op_q && !er_q) ? S_FD_RD : S_ST_RD;
					end
				end
				S_ST_RD: begin
					state_q <= S_ST_CHK;
				end
				S_ST_CHK: begin
					if (hit || pcnt_q == LAST_SLOT) begin
						if (er_q) begin
							epos_q  <= epos_inc;
							ecnt_q  <= ecnt_q + 1'b1;
							state_q <= S_ER_RD;
						end else begin
							ok_q    <= hit;
							ls_q    <= cur_q.side;
							lp_q    <= '{price: cur_q.price, qty: cur_q.qty};
							li_q    <= '0;
							state_q <= hit ? S_LA_RD : S_DONE;
						end
					end else begin
						pos_q   <= pos_inc;
						pcnt_q  <= pcnt_q + 1'b1;
						state_q <= S_ST_RD;
					end
				end
				S_FD_RD: begin
					state_q <= S_FD_CHK;
				end
				S_FD_CHK: begin
					if (!tbl_rd.used) begin
						ok_q    <= 1'b0;
						state_q <= S_DONE;
					end else if (alu.eq) begin
						ok_q    <= 1'b1;
						epos_q  <= pos_q;
						ls_q    <= tbl_rd.side;
						lp_q    <= '{price: tbl_rd.price, qty: tbl_rd.qty};
						li_q    <= '0;
						state_q <= S_LR_RD;
					end else if (pcnt_q == LAST_SLOT) begin
						ok_q    <= 1'b0;
						state_q <= S_DONE;
					end else begin
						pos_q   <= pos_inc;
						pcnt_q  <= pcnt_q + 1'b1;
						state_q <= S_FD_RD;
					end
				end
				S_ER_CLR: begin
					epos_q  <= epos_inc;
					ecnt_q  <= '0;
					state_q <= S_ER_RD;
				end
				S_ER_RD: begin
					state_q <= (ecnt_q == NUM_SLOTS) ? S_DONE : S_ER_CHK;
				end
				S_ER_CHK: begin
					if (!tbl_rd.used) begin
						state_q <= S_DONE;
					end else begin
						cur_q   <= tbl_rd;
						er_q    <= 1'b1;
						hcnt_q  <= '0;
						hph_q   <= 1'b0;
						hrem_q  <= '0;
						state_q <= S_HOME;
					end
				end
				S_LA_RD: begin
					if (li_q != n_cur) begin
						state_q <= S_LA_CHK;
					end else begin
						at_q    <= li_q;
						state_q <= (n_cur == LVL_MAX) ? S_DONE : S_LI_RD;
					end
				end
				S_LA_CHK: begin
					if (alu.eq) begin
						state_q <= S_DONE;
					end else if (better) begin
						at_q    <= li_q;
						li_q    <= n_cur;
						state_q <= (n_cur == LVL_MAX) ? S_DONE : S_LI_RD;
					end else begin
						li_q    <= li_q + 1'b1;
						state_q <= S_LA_RD;
					end
				end
				S_LI_RD: begin
					if (li_q == at_q) begin
						if (ls_q) begin
							bid_cnt_q <= bid_cnt_q + 1'b1;
						end else begin
							ask_cnt_q <= ask_cnt_q + 1'b1;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_LI_WR;
					end
				end
				S_LI_WR: begin
					li_q    <= li_q - 1'b1;
					state_q <= S_LI_RD;
				end
				S_LR_RD: begin
					state_q <= (li_q != n_cur) ? S_LR_CHK : S_ER_CLR;
				end
				S_LR_CHK: begin
					if (alu.eq) begin
						state_q <= alu.qle ? S_LD_RD : S_ER_CLR;
					end else begin
						li_q    <= li_q + 1'b1;
						state_q <= S_LR_RD;
					end
				end
				S_LD_RD: begin
					if (li_q + 1'b1 != n_cur) begin
						state_q <= S_LD_WR;
					end else begin
						if (ls_q) begin
							bid_cnt_q <= bid_cnt_q - 1'b1;
						end else begin
							ask_cnt_q <= ask_cnt_q - 1'b1;
						end
						state_q <= S_ER_CLR;
					end
				end
				S_LD_WR: begin
					li_q    <= li_q + 1'b1;
					state_q <= S_LD_RD;
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_ok_q    <= ok_q;
						m_data_q  <= {
							(ask_cnt_q != '0) ? best_ask_q.qty   : 32'd0,
							(ask_cnt_q != '0) ? best_ask_q.price : 64'd0,
							(bid_cnt_q != '0) ? best_bid_q.qty   : 32'd0,
							(bid_cnt_q != '0) ? best_bid_q.price : 64'd0};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_ok_q;

endmodule
